/* rtl/pcw_pkg.sv */
// Shared types, codes and exponential tables for the pairwise consistency weight block.
`default_nettype none
package pcw_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_SRC = 2'd0,
        OP_LOAD_TGT = 2'd1,
        OP_EVAL     = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_WEIGHT   = 3'd0,
        ST_SAME     = 3'd1,
        ST_INCONS   = 3'd2,
        ST_CLOSE    = 3'd3,
        ST_RANGE    = 3'd4
    } verdict_t;

    localparam logic [2:0] CFG_EPSILON  = 3'd0;
    localparam logic [2:0] CFG_MIN_DIST = 3'd1;
    localparam logic [2:0] CFG_SRC_CNT  = 3'd2;
    localparam logic [2:0] CFG_TGT_CNT  = 3'd3;

    localparam int CFG_DATA_BITS = 17;
    localparam int CONS_BITS     = 17;
    localparam int WEIGHT_BITS   = 16;
    localparam int INDEX_BITS    = 6;
    localparam int COUNT_BITS    = 7;

    typedef struct packed {
        logic                   has_weight;
        logic [WEIGHT_BITS-1:0] weight;
        logic [CONS_BITS-1:0]   cons;
        verdict_t               status;
    } result_t;

    // exp(-q) scaled by 65536; zero once q reaches twelve.
    function automatic logic [16:0] exp_q(input logic [3:0] q);
        logic [16:0] r;
        case (q)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd24109;
            4'd2:    r = 17'd8869;
            4'd3:    r = 17'd3263;
            4'd4:    r = 17'd1200;
            4'd5:    r = 17'd442;
            4'd6:    r = 17'd162;
            4'd7:    r = 17'd60;
            4'd8:    r = 17'd22;
            4'd9:    r = 17'd8;
            4'd10:   r = 17'd3;
            4'd11:   r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    function automatic logic [16:0] exp_h(input logic [3:0] h);
        logic [16:0] r;
        case (h)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd61565;
            4'd2:    r = 17'd57835;
            4'd3:    r = 17'd54331;
            4'd4:    r = 17'd51039;
            4'd5:    r = 17'd47947;
            4'd6:    r = 17'd45042;
            4'd7:    r = 17'd42313;
            4'd8:    r = 17'd39750;
            4'd9:    r = 17'd37341;
            4'd10:   r = 17'd35079;
            4'd11:   r = 17'd32954;
            4'd12:   r = 17'd30957;
            4'd13:   r = 17'd29081;
            4'd14:   r = 17'd27319;
            default: r = 17'd25664;
        endcase
        return r;
    endfunction

    function automatic logic [16:0] exp_m(input logic [3:0] m);
        logic [16:0] r;
        case (m)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd65280;
            4'd2:    r = 17'd65026;
            4'd3:    r = 17'd64772;
            4'd4:    r = 17'd64520;
            4'd5:    r = 17'd64268;
            4'd6:    r = 17'd64018;
            4'd7:    r = 17'd63768;
            4'd8:    r = 17'd63520;
            4'd9:    r = 17'd63272;
            4'd10:   r = 17'd63025;
            4'd11:   r = 17'd62780;
            4'd12:   r = 17'd62535;
            4'd13:   r = 17'd62291;
            4'd14:   r = 17'd62048;
            default: r = 17'd61806;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/pcw_store.sv */
// Point memory with one write port and two registered read ports.
`default_nettype none
module pcw_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 48
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr_a,
    input  wire logic [AW-1:0] raddr_b,
    output logic      [DW-1:0] rdata_a,
    output logic      [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule
`default_nettype wire

/* rtl/pcw_sqdist.sv */
// Two-stage squared Euclidean distance with saturation to VW bits.
`default_nettype none
module pcw_sqdist #(
    parameter int CB = 16,
    parameter int VW = 36
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [3*CB-1:0] pa,
    input  wire logic [3*CB-1:0] pb,
    output logic      [VW-1:0] sum_sat
);

    localparam int DW = CB + 1;
    localparam int QW = 2 * DW;
    localparam int SW = QW + 2;

    logic [QW-1:0] sq_reg   [3];
    logic [QW-1:0] sq_next  [3];
    logic [SW-1:0] sum;
    logic [VW-1:0] sat_next;

    always_comb
    begin
        for (int n = 0; n < 3; n++)
        begin
            logic signed [DW-1:0] d;
            logic        [DW-1:0] m;
            d = DW'($signed(pa[n*CB +: CB])) - DW'($signed(pb[n*CB +: CB]));
            m = d[DW-1] ? DW'(-d) : DW'(d);
            sq_next[n] = QW'(m) * QW'(m);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int n = 0; n < 3; n++)
            begin
                sq_reg[n] <= sq_next[n];
            end
        end
    end

    always_comb
    begin
        sum = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
        if (SW > VW && (sum >> VW) != '0)
        begin
            sat_next = '1;
        end
        else
        begin
            sat_next = sum[VW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_sat <= sat_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/pcw_isqrt.sv */
// Pipelined floor square root, one result bit per stage.
`default_nettype none
module pcw_isqrt #(
    parameter int VW = 36
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [VW-1:0]     val,
    output logic      [VW/2-1:0]   root
);

    localparam int RW  = VW / 2;
    localparam int RMW = RW + 2;

    logic [RMW-1:0] rem_reg  [RW+1];
    logic [RW-1:0]  root_reg [RW+1];
    logic [VW-1:0]  val_reg  [RW+1];

    assign rem_reg[0]  = '0;
    assign root_reg[0] = '0;
    assign val_reg[0]  = val;

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        logic [RMW-1:0] shifted;
        logic [RMW-1:0] trial;
        logic           fits;

        always_comb
        begin
            shifted = {rem_reg[k][RMW-3:0], val_reg[k][VW-1:VW-2]};
            trial   = {root_reg[k], 2'b01};
            fits    = shifted >= trial;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= fits ? shifted - trial : shifted;
                root_reg[k+1] <= {root_reg[k][RW-2:0], fits};
                val_reg[k+1]  <= val_reg[k] << 2;
            end
        end
    end

    assign root = root_reg[RW];

endmodule
`default_nettype wire

/* rtl/pcw_weight.sv */
// Three-stage table exponential and result formatting.
`default_nettype none
module pcw_weight
    import pcw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [CONS_BITS-1:0] cons,
    input  wire verdict_t             status,
    output result_t                   result
);

    logic [32:0]          p1_reg;
    logic [3:0]           m_reg;
    verdict_t             st1_reg;
    logic [CONS_BITS-1:0] c1_reg;
    logic [32:0]          p2_reg;
    verdict_t             st2_reg;
    logic [CONS_BITS-1:0] c2_reg;
    logic [16:0]          e1;
    logic [16:0]          e2;
    logic [15:0]          mag;
    logic [16:0]          neg;
    logic [32:0]          p1_next;
    logic [32:0]          p2_next;
    logic [3:0]           q;
    result_t              result_next;

    always_comb
    begin
        q = (cons[16:12] != '0) ? 4'd15 : cons[11:8];
        p1_next = 33'(exp_q(q)) * 33'(exp_h(cons[7:4]));
        e1 = 17'((p1_reg + 33'd32768) >> 16);
        p2_next = 33'(e1) * 33'(exp_m(m_reg));
        e2 = 17'((p2_reg + 33'd32768) >> 16);
        mag = 16'((18'(e2) + 18'd1) >> 1);
        neg = 17'h10000 - 17'(mag);
        result_next.has_weight = (st2_reg == ST_WEIGHT);
        result_next.weight     = (st2_reg == ST_WEIGHT) ? neg[15:0] : '0;
        result_next.cons       = c2_reg;
        result_next.status     = st2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= p1_next;
            m_reg   <= cons[3:0];
            st1_reg <= status;
            c1_reg  <= cons;
            p2_reg  <= p2_next;
            st2_reg <= st1_reg;
            c2_reg  <= c1_reg;
            result  <= result_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/pairwise_consistency_weight.sv */
// Top level: point stores, distance pipeline and weight output.
//
//   channel | direction | beat carries
//   in      | input     | operation, point_slot, coordinates, four indices
//   out     | output    | has_weight, weight_value, consistency_value, result_status
//   cfg     | input     | cfg_index, cfg_data
//
// One beat is accepted per cycle while the output is not stalled; an evaluate result is
// registered through the store read, distance, square root, verdict and weight stages.
// Loads write the stores at acceptance and produce no result.
// Reset clears the pipeline valids and restores the configuration defaults; stores are not cleared.
// A stalled output beat freezes the whole pipeline, so in_ready is low only while one is stalled.
`default_nettype none
module pairwise_consistency_weight
    import pcw_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [1:0]               operation,
    input  wire logic [INDEX_BITS-1:0]    point_slot,
    input  wire logic [COORD_BITS-1:0]    coord_x,
    input  wire logic [COORD_BITS-1:0]    coord_y,
    input  wire logic [COORD_BITS-1:0]    coord_z,
    input  wire logic [INDEX_BITS-1:0]    src_first,
    input  wire logic [INDEX_BITS-1:0]    tgt_first,
    input  wire logic [INDEX_BITS-1:0]    src_second,
    input  wire logic [INDEX_BITS-1:0]    tgt_second,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          has_weight,
    output logic signed [WEIGHT_BITS-1:0] weight_value,
    output logic [CONS_BITS-1:0]          consistency_value,
    output logic [2:0]                    result_status,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [2:0]               cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int DW  = 3 * COORD_BITS;
    localparam int SW  = 2 * COORD_BITS + 4;
    localparam int VW  = (SW > 64) ? 64 : SW;
    localparam int RW  = VW / 2;
    localparam int CW  = (RW > CONS_BITS) ? RW : CONS_BITS;
    localparam int PD  = RW + 3;
    localparam int L   = RW + 7;
    localparam logic [10:0] MAXP = 11'(MAX_POINTS);

    logic [CFG_DATA_BITS-1:0] eps_reg;
    logic [CFG_DATA_BITS-1:0] mind_reg;
    logic [COUNT_BITS-1:0]    scnt_reg;
    logic [COUNT_BITS-1:0]    tcnt_reg;
    logic [L-1:0]             v_reg;
    logic [L-1:0]             v_next;
    verdict_t                 pre_reg [PD];
    verdict_t                 pre_next;
    logic                     adv;
    logic                     acc;
    logic [10:0]              sc;
    logic [10:0]              tc;
    logic                     slot_ok;
    logic                     we_src;
    logic                     we_tgt;
    logic [DW-1:0]            wdata;
    logic [DW-1:0]            si;
    logic [DW-1:0]            sk;
    logic [DW-1:0]            tj;
    logic [DW-1:0]            tl;
    logic [VW-1:0]            ssum;
    logic [VW-1:0]            tsum;
    logic [RW-1:0]            ds;
    logic [RW-1:0]            dt;
    logic [CW-1:0]            ce;
    logic [CONS_BITS-1:0]     c_reg;
    logic [CONS_BITS-1:0]     c_next;
    verdict_t                 st_reg;
    verdict_t                 st_next;
    result_t                  res;

    assign adv       = !v_reg[L-1] || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;
    assign acc       = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg  <= 17'd256;
            mind_reg <= '0;
            scnt_reg <= 7'd64;
            tcnt_reg <= 7'd64;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_EPSILON:  eps_reg  <= cfg_data;
                CFG_MIN_DIST: mind_reg <= cfg_data;
                CFG_SRC_CNT:  scnt_reg <= cfg_data[COUNT_BITS-1:0];
                CFG_TGT_CNT:  tcnt_reg <= cfg_data[COUNT_BITS-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        sc = (11'(scnt_reg) < MAXP) ? 11'(scnt_reg) : MAXP;
        tc = (11'(tcnt_reg) < MAXP) ? 11'(tcnt_reg) : MAXP;
        slot_ok = 11'(point_slot) < MAXP;
        we_src = acc && (operation == OP_LOAD_SRC) && slot_ok;
        we_tgt = acc && (operation == OP_LOAD_TGT) && slot_ok;
        wdata = {coord_z, coord_y, coord_x};
        if (11'(src_first) >= sc || 11'(src_second) >= sc ||
            11'(tgt_first) >= tc || 11'(tgt_second) >= tc)
        begin
            pre_next = ST_RANGE;
        end
        else if (src_first == src_second || tgt_first == tgt_second)
        begin
            pre_next = ST_SAME;
        end
        else
        begin
            pre_next = ST_WEIGHT;
        end
        v_next = {v_reg[L-2:0], acc && (operation == OP_EVAL)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pre_reg[0] <= pre_next;
            for (int n = 1; n < PD; n++)
            begin
                pre_reg[n] <= pre_reg[n-1];
            end
        end
    end

    pcw_store #(.DEPTH(MAX_POINTS), .AW(AW), .DW(DW)) u_src (
        .clk     (clk),
        .we      (we_src),
        .waddr   (AW'(point_slot)),
        .wdata   (wdata),
        .re      (adv),
        .raddr_a (AW'(src_first)),
        .raddr_b (AW'(src_second)),
        .rdata_a (si),
        .rdata_b (sk)
    );

    pcw_store #(.DEPTH(MAX_POINTS), .AW(AW), .DW(DW)) u_tgt (
        .clk     (clk),
        .we      (we_tgt),
        .waddr   (AW'(point_slot)),
        .wdata   (wdata),
        .re      (adv),
        .raddr_a (AW'(tgt_first)),
        .raddr_b (AW'(tgt_second)),
        .rdata_a (tj),
        .rdata_b (tl)
    );

    pcw_sqdist #(.CB(COORD_BITS), .VW(VW)) u_sqd_src (
        .clk     (clk),
        .en      (adv),
        .pa      (si),
        .pb      (sk),
        .sum_sat (ssum)
    );

    pcw_sqdist #(.CB(COORD_BITS), .VW(VW)) u_sqd_tgt (
        .clk     (clk),
        .en      (adv),
        .pa      (tj),
        .pb      (tl),
        .sum_sat (tsum)
    );

    pcw_isqrt #(.VW(VW)) u_sqrt_src (
        .clk  (clk),
        .en   (adv),
        .val  (ssum),
        .root (ds)
    );

    pcw_isqrt #(.VW(VW)) u_sqrt_tgt (
        .clk  (clk),
        .en   (adv),
        .val  (tsum),
        .root (dt)
    );

    always_comb
    begin
        ce = (ds > dt) ? CW'(ds - dt) : CW'(dt - ds);
        if (pre_reg[PD-1] != ST_WEIGHT)
        begin
            st_next = pre_reg[PD-1];
            c_next  = '0;
        end
        else
        begin
            if (ce >= CW'(eps_reg))
            begin
                st_next = ST_INCONS;
            end
            else if (CW'(ds) <= CW'(mind_reg))
            begin
                st_next = ST_CLOSE;
            end
            else
            begin
                st_next = ST_WEIGHT;
            end
            c_next = (ce > CW'(17'h1FFFF)) ? '1 : ce[CONS_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg <= st_next;
            c_reg  <= c_next;
        end
    end

    pcw_weight u_weight (
        .clk    (clk),
        .en     (adv),
        .cons   (c_reg),
        .status (st_reg),
        .result (res)
    );

    assign out_valid         = v_reg[L-1];
    assign has_weight        = res.has_weight;
    assign weight_value      = res.weight;
    assign consistency_value = res.cons;
    assign result_status     = res.status;

endmodule
`default_nettype wire

/* rtl/pcw_checker.sv */
// Port-level checks for the pairwise consistency weight block and their binding.
`default_nettype none
module pcw_checker
    import pcw_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_ready,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic                   has_weight,
    input wire logic [WEIGHT_BITS-1:0] weight_value,
    input wire logic [CONS_BITS-1:0]   consistency_value,
    input wire logic [2:0]             result_status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(weight_value) &&
        $stable(consistency_value) && $stable(result_status))
        else $error("Output beat changed while stalled.");

    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> has_weight == (result_status == ST_WEIGHT))
        else $error("Weight flag disagrees with status.");

    a_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_weight |-> weight_value == '0)
        else $error("Weight is nonzero without a weight entry.");

    a_zero_cons: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_status == ST_SAME || result_status == ST_RANGE)
        |-> consistency_value == '0)
        else $error("Consistency reported for a rejected quadruple.");

    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("Input taken while the pipeline is frozen.");

endmodule

bind pairwise_consistency_weight pcw_checker u_pcw_checker (.*);
`default_nettype wire

/* dv/tb_pairwise_consistency_weight.sv */
// Self-checking testbench for the pairwise consistency weight block.
`default_nettype none
module tb_pairwise_consistency_weight;
    import pcw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 24;
    localparam int IDLE_LIMIT = 3000;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        op_t         op;
        logic [5:0]  slot;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [5:0]  i;
        logic [5:0]  j;
        logic [5:0]  k;
        logic [5:0]  l;
    } beat_t;

    typedef struct packed {
        logic        is_cfg;
        logic [2:0]  cidx;
        logic [16:0] cval;
        beat_t       b;
        logic        typed;
        result_t     want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  operation = '0;
    logic [5:0]  point_slot = '0;
    logic [15:0] coord_x = '0;
    logic [15:0] coord_y = '0;
    logic [15:0] coord_z = '0;
    logic [5:0]  src_first = '0;
    logic [5:0]  tgt_first = '0;
    logic [5:0]  src_second = '0;
    logic [5:0]  tgt_second = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        has_weight;
    logic signed [15:0] weight_value;
    logic [16:0] consistency_value;
    logic [2:0]  result_status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [16:0] cfg_data = '0;

    pairwise_consistency_weight uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .point_slot(point_slot),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .src_first(src_first), .tgt_first(tgt_first),
        .src_second(src_second), .tgt_second(tgt_second),
        .out_valid(out_valid), .out_ready(out_ready),
        .has_weight(has_weight), .weight_value(weight_value),
        .consistency_value(consistency_value), .result_status(result_status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    localparam int unsigned EXP_Q [12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
                                           22, 8, 3, 1};
    localparam int unsigned EXP_H [16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042,
                                           42313, 39750, 37341, 35079, 32954, 30957, 29081,
                                           27319, 25664};
    localparam int unsigned EXP_M [16] = '{65536, 65280, 65026, 64772, 64520, 64268, 64018,
                                           63768, 63520, 63272, 63025, 62780, 62535, 62291,
                                           62048, 61806};

    logic signed [15:0] src_pts [64][3];
    logic signed [15:0] tgt_pts [64][3];
    logic [16:0] eps_reg;
    logic [16:0] min_dist_reg;
    logic [6:0]  src_cnt_reg;
    logic [6:0]  tgt_cnt_reg;

    result_t pending_results [$];
    int fail_count = 0;
    int eval_count = 0;
    int weight_count = 0;
    int cfg_count = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit quiet_output = 0;
    bit quiet_input = 0;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned pair_distance(input logic signed [15:0] a [3],
                                                      input logic signed [15:0] b [3]);
        longint unsigned sum;
        longint d;
        sum = 0;
        for (int n = 0; n < 3; n++)
        begin
            d = longint'(a[n]) - longint'(b[n]);
            sum = sum + longint'(d * d);
        end
        return int_sqrt(sum);
    endfunction

    function automatic logic [15:0] neg_exp_weight(input longint unsigned c);
        longint unsigned e;
        longint unsigned mag;
        if ((c >> 8) >= 12)
            return 16'd0;
        e = (longint'(EXP_Q[c >> 8]) * EXP_H[(c >> 4) & 15] + 32768) >> 16;
        e = (e * EXP_M[c & 15] + 32768) >> 16;
        mag = (e + 1) >> 1;
        return 16'((17'h10000 - mag));
    endfunction

    function automatic result_t predict_eval(input beat_t b);
        result_t r;
        longint unsigned ds;
        longint unsigned dt;
        longint unsigned c;
        int sc;
        int tc;
        r = '0;
        sc = (src_cnt_reg < 64) ? src_cnt_reg : 64;
        tc = (tgt_cnt_reg < 64) ? tgt_cnt_reg : 64;
        if (b.i >= sc || b.k >= sc || b.j >= tc || b.l >= tc)
        begin
            r.status = ST_RANGE;
            return r;
        end
        if (b.i == b.k || b.j == b.l)
        begin
            r.status = ST_SAME;
            return r;
        end
        ds = pair_distance(src_pts[b.i], src_pts[b.k]);
        dt = pair_distance(tgt_pts[b.j], tgt_pts[b.l]);
        c = (ds > dt) ? ds - dt : dt - ds;
        r.cons = (c > 17'h1FFFF) ? 17'h1FFFF : c[16:0];
        if (c >= eps_reg)
            r.status = ST_INCONS;
        else if (ds <= min_dist_reg)
            r.status = ST_CLOSE;
        else
        begin
            r.status = ST_WEIGHT;
            r.has_weight = 1'b1;
            r.weight = neg_exp_weight(c);
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (quiet_input || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_count++;
        case (idx)
            CFG_EPSILON:  eps_reg = val;
            CFG_MIN_DIST: min_dist_reg = val;
            CFG_SRC_CNT:  src_cnt_reg = val[6:0];
            CFG_TGT_CNT:  tgt_cnt_reg = val[6:0];
            default: ;
        endcase
    endtask

    task automatic send_beat(input beat_t b, input bit typed, input result_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= b.op;
        point_slot <= b.slot;
        coord_x <= b.x;
        coord_y <= b.y;
        coord_z <= b.z;
        src_first <= b.i;
        tgt_first <= b.j;
        src_second <= b.k;
        tgt_second <= b.l;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        case (b.op)
            OP_LOAD_SRC: src_pts[b.slot] = '{b.x, b.y, b.z};
            OP_LOAD_TGT: tgt_pts[b.slot] = '{b.x, b.y, b.z};
            OP_EVAL:
            begin
                eval_count++;
                pending_results.push_back(typed ? want : predict_eval(b));
            end
            default: ;
        endcase
    endtask

    function automatic beat_t load_beat(input op_t op, input logic [5:0] slot,
                                        input logic [15:0] x, input logic [15:0] y,
                                        input logic [15:0] z);
        beat_t b;
        b = beat_t'($urandom());
        b.op = op;
        b.slot = slot;
        b.x = x;
        b.y = y;
        b.z = z;
        return b;
    endfunction

    function automatic beat_t eval_beat(input logic [5:0] i, input logic [5:0] j,
                                        input logic [5:0] k, input logic [5:0] l);
        beat_t b;
        b = beat_t'({$urandom(), $urandom(), $urandom()});
        b.op = OP_EVAL;
        b.i = i;
        b.j = j;
        b.k = k;
        b.l = l;
        return b;
    endfunction

    function automatic row_t beat_row(input beat_t b, input bit typed, input result_t want);
        row_t r;
        r = '0;
        r.b = b;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    function automatic row_t cfg_row(input logic [2:0] idx, input logic [16:0] val);
        row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.cidx = idx;
        r.cval = val;
        return r;
    endfunction

    function automatic logic [15:0] jitter(input logic [15:0] v, input int amp);
        int n;
        n = int'($signed(v)) + $urandom_range(2 * amp) - amp;
        if (n > 32767)
            n = 32767;
        if (n < -32768)
            n = -32768;
        return n[15:0];
    endfunction

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
        if (out_valid && out_ready)
        begin
            got = '{has_weight, weight_value, consistency_value, verdict_t'(result_status)};
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, got);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.has_weight !== want.has_weight)
                begin
                    $display("%0t: has_weight expected %0d actual %0d", $time,
                             want.has_weight, got.has_weight);
                    fail_count++;
                end
                if (got.weight !== want.weight)
                begin
                    $display("%0t: weight_value expected %0d actual %0d", $time,
                             $signed(want.weight), $signed(got.weight));
                    fail_count++;
                end
                if (got.cons !== want.cons)
                begin
                    $display("%0t: consistency_value expected %0d actual %0d", $time,
                             want.cons, got.cons);
                    fail_count++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: result_status expected %0d actual %0d", $time,
                             want.status, got.status);
                    fail_count++;
                end
                if (want.has_weight)
                    weight_count++;
            end
        end
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!quiet_output && $urandom_range(7) == 0)
                stall_left = ($urandom_range(9) == 0) ? $urandom_range(20, 40)
                                                        : $urandom_range(1, 4);
        end
    end

    initial
    begin
        row_t dir [$];
        result_t same_r;
        result_t range_r;
        result_t unit_r;
        beat_t b;
        logic [16:0] eps_set [6];
        logic [16:0] min_set [6];
        logic [6:0] sc_set [6];
        logic [6:0] tc_set [6];
        logic signed [15:0] off [3];
        int amp;
        int roll;
        int sc;
        int tc;

        eps_reg = 17'd256;
        min_dist_reg = '0;
        src_cnt_reg = 7'd64;
        tgt_cnt_reg = 7'd64;
        for (int s = 0; s < 64; s++)
            for (int n = 0; n < 3; n++)
            begin
                src_pts[s][n] = '0;
                tgt_pts[s][n] = '0;
            end
        same_r = '0;
        same_r.status = ST_SAME;
        range_r = '0;
        range_r.status = ST_RANGE;
        unit_r = '{1'b1, 16'h8000, 17'd0, ST_WEIGHT};

        dir.push_back(beat_row(load_beat(OP_LOAD_SRC, 0, 0, 0, 0), 0, '0));
        dir.push_back(beat_row(load_beat(OP_LOAD_SRC, 1, 16'd256, 0, 0), 0, '0));
        dir.push_back(beat_row(load_beat(OP_LOAD_SRC, 2, 16'h8000, 16'h8000, 16'h8000), 0, '0));
        dir.push_back(beat_row(load_beat(OP_LOAD_SRC, 3, 16'h7FFF, 16'h7FFF, 16'h7FFF), 0, '0));
        dir.push_back(beat_row(load_beat(OP_LOAD_TGT, 0, 0, 0, 0), 0, '0));
        dir.push_back(beat_row(load_beat(OP_LOAD_TGT, 1, 16'd256, 0, 0), 0, '0));
        dir.push_back(beat_row(load_beat(OP_LOAD_TGT, 2, 16'h7FFF, 16'h8000, 16'h7FFF), 0, '0));
        dir.push_back(beat_row(load_beat(OP_LOAD_TGT, 3, 16'h8000, 16'h7FFF, 16'h8000), 0, '0));
        dir.push_back(beat_row(eval_beat(0, 0, 1, 1), 1, unit_r));
        dir.push_back(beat_row(eval_beat(1, 0, 1, 2), 1, same_r));
        dir.push_back(beat_row(eval_beat(0, 1, 2, 1), 1, same_r));
        dir.push_back(beat_row(eval_beat(2, 2, 3, 3), 0, '0));
        dir.push_back(beat_row(eval_beat(2, 0, 3, 1), 0, '0));
        dir.push_back(beat_row(eval_beat(0, 2, 1, 3), 0, '0));
        dir.push_back(beat_row(eval_beat(0, 0, 3, 1), 0, '0));
        b = load_beat(OP_NONE, 6'h3F, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        b.i = 6'h3F; b.j = 6'h3F; b.k = 6'h3F; b.l = 6'h3F;
        dir.push_back(beat_row(b, 0, '0));
        dir.push_back(beat_row(eval_beat(0, 1, 1, 0), 0, '0));
        dir.push_back(cfg_row(CFG_SRC_CNT, 17'd2));
        dir.push_back(cfg_row(CFG_TGT_CNT, 17'd2));
        dir.push_back(beat_row(eval_beat(0, 0, 3, 1), 1, range_r));
        dir.push_back(beat_row(eval_beat(0, 3, 1, 0), 1, range_r));
        dir.push_back(beat_row(eval_beat(2, 0, 2, 1), 1, range_r));
        dir.push_back(beat_row(eval_beat(1, 1, 0, 0), 0, '0));
        dir.push_back(cfg_row(CFG_UNUSED, 17'h1FFFF));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir[r])
            if (dir[r].is_cfg)
                write_reg(dir[r].cidx, dir[r].cval);
            else
                send_beat(dir[r].b, dir[r].typed, dir[r].want);

        write_reg(CFG_SRC_CNT, 17'd64);
        write_reg(CFG_TGT_CNT, 17'd64);
        off = '{$urandom_range(2000), $urandom_range(2000), $urandom_range(2000)};
        for (int s = 0; s < 64; s++)
        begin
            b = load_beat(OP_LOAD_SRC, s, $urandom_range(16000) - 8000,
                          $urandom_range(16000) - 8000, $urandom_range(16000) - 8000);
            send_beat(b, 0, '0);
            send_beat(load_beat(OP_LOAD_TGT, s, jitter(b.x + off[0], 20),
                                jitter(b.y + off[1], 20), jitter(b.z + off[2], 20)), 0, '0);
        end

        eps_set = '{17'd256, 17'h1FFFF, 17'd0, 17'd40, 17'd1000, 17'd64};
        min_set = '{17'd0, 17'h1FFFF, 17'd0, 17'd3000, 17'd100, 17'd0};
        sc_set  = '{7'd64, 7'd1, 7'd64, 7'd16, 7'd5, 7'd64};
        tc_set  = '{7'd64, 7'd64, 7'd1, 7'd16, 7'd64, 7'd3};
        for (int p = 0; p < 6; p++)
        begin
            write_reg(CFG_EPSILON, eps_set[p]);
            write_reg(CFG_MIN_DIST, min_set[p]);
            write_reg(CFG_SRC_CNT, 17'(sc_set[p]));
            write_reg(CFG_TGT_CNT, 17'(tc_set[p]));
            quiet_output = (p == 2);
            quiet_input = (p == 3);
            amp = (p == 4) ? 2000 : $urandom_range(1, 60);
            sc = sc_set[p];
            tc = tc_set[p];
            for (int n = 0; n < 195; n++)
            begin
                if (n == 100)
                    wait_drained();
                roll = $urandom_range(99);
                if (roll < 68)
                begin
                    if ($urandom_range(9) == 0)
                        b = eval_beat($urandom_range(63), $urandom_range(63),
                                      $urandom_range(63), $urandom_range(63));
                    else
                    begin
                        b = eval_beat($urandom_range(sc - 1), 0, $urandom_range(sc - 1), 0);
                        b.j = ($urandom_range(3) != 0 && b.i < tc) ? b.i
                                                                   : $urandom_range(tc - 1);
                        b.l = ($urandom_range(3) != 0 && b.k < tc) ? b.k
                                                                   : $urandom_range(tc - 1);
                    end
                    send_beat(b, 0, '0);
                end
                else if (roll < 80)
                begin
                    b = load_beat(OP_LOAD_SRC, $urandom_range(63), $urandom(), $urandom(),
                                  $urandom());
                    if ($urandom_range(3) != 0)
                    begin
                        b.x = $urandom_range(16000) - 8000;
                        b.y = $urandom_range(16000) - 8000;
                        b.z = $urandom_range(16000) - 8000;
                    end
                    send_beat(b, 0, '0);
                    send_beat(load_beat(OP_LOAD_TGT, b.slot, jitter(b.x, amp),
                                        jitter(b.y, amp), jitter(b.z, amp)), 0, '0);
                end
                else if (roll < 95)
                    send_beat(load_beat(op_t'($urandom_range(1)), $urandom_range(63),
                                        $urandom(), $urandom(), $urandom()), 0, '0);
                else
                    send_beat(load_beat(OP_NONE, $urandom(), $urandom(), $urandom(),
                                        $urandom()), 0, '0);
            end
        end

        quiet_output = 0;
        wait_drained();
        $display("Covered %0d evaluations (%0d with a weight) across %0d register writes,",
                 eval_count, weight_count, cfg_count);
        $display("with point loads, ignored beats and random stalls on both channels.");
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire

/* pairwise_consistency_weight.f */
rtl/pcw_pkg.sv
rtl/pcw_store.sv
rtl/pcw_sqdist.sv
rtl/pcw_isqrt.sv
rtl/pcw_weight.sv
rtl/pairwise_consistency_weight.sv
rtl/pcw_checker.sv
dv/tb_pairwise_consistency_weight.sv
